// ===== src/rcw_pkg.sv =====
`default_nettype none

package rcw_pkg;

    // Screen geometry.
    localparam int unsigned SCREEN_ROWS = 512;

    // Field widths.
    localparam int unsigned DIST_W  = 33;
    localparam int unsigned MAG_W   = 32;
    localparam int unsigned DIR_W   = 16;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned FRAC_W  = 30;
    localparam int unsigned H_W     = 16;
    localparam int unsigned ROW_W   = 12;
    localparam int unsigned TEX_W   = 10;
    localparam int unsigned CFG_W   = 11;

    // Row arithmetic is done in this width so that no intermediate overflows.
    localparam int unsigned ROWCALC_W = 17;

    // One quotient bit is resolved per divider stage.
    localparam int unsigned DIV_STAGES = 16;

    // Stages of the back pipeline that host the texture column steps.
    localparam int unsigned STG_MUL    = 1;
    localparam int unsigned STG_FRAC   = 2;
    localparam int unsigned STG_SCALE  = 3;
    localparam int unsigned STG_MIRROR = 4;

    // Queue between the front and the back.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;
    localparam int unsigned Q_CW    = 3;

    // Configuration port.
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [0:0]  REG_TEXTURE_WIDTH = 1'b0;
    localparam logic [CFG_W-1:0] TEX_WIDTH_RESET = 11'd64;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic [DIST_W-1:0] perp_dist;
        logic [MAG_W-1:0]  mag;
        logic [DIR_W-1:0]  dir;
        logic [POS_W-1:0]  pos;
        logic              flip;
    } t_item;

    // Contents of one back pipeline stage.
    typedef struct packed {
        logic [DIST_W-1:0] rem;
        logic [H_W-1:0]    quo;
        logic [MAG_W-1:0]  mag;
        logic              sat;
        logic              zero;
        logic [DIST_W-1:0] perp_dist;
        logic [DIR_W-1:0]  dir;
        logic [POS_W-1:0]  pos;
        logic              flip;
        logic [FRAC_W-1:0] frac;
        logic [CFG_W-1:0]  tex;
    } t_stage;

endpackage

`default_nettype wire

// ===== src/raycast_wall_column_setup_unit.sv =====
// Path: front register, queue, load stage, 16 divider stages, then the output register.
// Throughput: one request per cycle while the output is not stalled; the 16-stage divider resolves one quotient bit
// per stage and the texture multipliers sit in parallel stages of the same pipe.
// A stalled output freezes the back pipe; a 4-entry queue and the front register
// keep accepting until they fill. Synchronous active-low reset clears all valids
// and sets texture_width to 64; there is no clearing pass.
`default_nettype none

module raycast_wall_column_setup_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request channel.
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_hit_side,
    input  wire logic [31:0]                   i_side_dist_x,
    input  wire logic [31:0]                   i_delta_dist_x,
    input  wire logic [31:0]                   i_side_dist_y,
    input  wire logic [31:0]                   i_delta_dist_y,
    input  wire logic signed [15:0]            i_ray_dir_x,
    input  wire logic signed [15:0]            i_ray_dir_y,
    input  wire logic [23:0]                   i_viewer_x,
    input  wire logic [23:0]                   i_viewer_y,
    // Result channel.
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [rcw_pkg::H_W-1:0]            o_slice_height,
    output logic [rcw_pkg::ROW_W-1:0]          o_first_row,
    output logic [rcw_pkg::ROW_W-1:0]          o_last_row,
    output logic [rcw_pkg::TEX_W-1:0]          o_texel_column,
    output logic                               o_zero_distance,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rcw_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [rcw_pkg::PDATA_W-1:0]   pwdata,
    output logic [rcw_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    logic [rcw_pkg::CFG_W-1:0] r_tex_width;
    logic                      front_valid;
    rcw_pkg::t_item            front_item;
    logic                      front_ready;
    logic                      q_valid;
    rcw_pkg::t_item            q_item;
    logic                      q_ready;
    logic                      reg_sel;

    // Register decode: one word-aligned register.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[rcw_pkg::PADDR_W-1] == rcw_pkg::REG_TEXTURE_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width <= rcw_pkg::TEX_WIDTH_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_tex_width <= pwdata[rcw_pkg::CFG_W-1:0];
        end
    end

    assign prdata = reg_sel ? rcw_pkg::PDATA_W'(r_tex_width) : '0;

    // Front: accept and classify.
    rcw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_hit_side     (i_hit_side),
        .i_side_dist_x  (i_side_dist_x),
        .i_delta_dist_x (i_delta_dist_x),
        .i_side_dist_y  (i_side_dist_y),
        .i_delta_dist_y (i_delta_dist_y),
        .i_ray_dir_x    (i_ray_dir_x),
        .i_ray_dir_y    (i_ray_dir_y),
        .i_viewer_x     (i_viewer_x),
        .i_viewer_y     (i_viewer_y),
        .o_item_valid   (front_valid),
        .o_item         (front_item),
        .i_item_ready   (front_ready)
    );

    // Queue between front and back.
    rcw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_item  (front_item),
        .o_push_ready (front_ready),
        .o_pop_valid  (q_valid),
        .o_pop_item   (q_item),
        .i_pop_ready  (q_ready)
    );

    // Back: divider, texture column and row clamping.
    rcw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (q_valid),
        .i_item          (q_item),
        .o_item_ready    (q_ready),
        .i_tex_width     (r_tex_width),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_slice_height  (o_slice_height),
        .o_first_row     (o_first_row),
        .o_last_row      (o_last_row),
        .o_texel_column  (o_texel_column),
        .o_zero_distance (o_zero_distance)
    );

endmodule

`default_nettype wire

// ===== src/rcw_front.sv =====
`default_nettype none

module rcw_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_hit_side,
    input  wire logic [31:0]                i_side_dist_x,
    input  wire logic [31:0]                i_delta_dist_x,
    input  wire logic [31:0]                i_side_dist_y,
    input  wire logic [31:0]                i_delta_dist_y,
    input  wire logic signed [15:0]         i_ray_dir_x,
    input  wire logic signed [15:0]         i_ray_dir_y,
    input  wire logic [23:0]                i_viewer_x,
    input  wire logic [23:0]                i_viewer_y,
    output logic                            o_item_valid,
    output rcw_pkg::t_item                  o_item,
    input  wire logic                       i_item_ready
);

    logic           r_valid;
    rcw_pkg::t_item r_item;
    rcw_pkg::t_item n_item;
    logic [31:0]    side_sel;
    logic [31:0]    delta_sel;
    logic [32:0]    diff_fwd;
    logic [32:0]    diff_rev;
    logic           accept;
    logic           push;

    // Pick the axis that was hit and form the signed distance and its magnitude.
    always_comb begin
        side_sel    = i_hit_side ? i_side_dist_y  : i_side_dist_x;
        delta_sel   = i_hit_side ? i_delta_dist_y : i_delta_dist_x;
        diff_fwd    = {1'b0, side_sel} - {1'b0, delta_sel};
        diff_rev    = {1'b0, delta_sel} - {1'b0, side_sel};
        n_item.perp_dist = diff_fwd;
        n_item.mag  = diff_fwd[32] ? diff_rev[31:0] : diff_fwd[31:0];
        n_item.dir  = i_hit_side ? i_ray_dir_x : i_ray_dir_y;
        n_item.pos  = i_hit_side ? i_viewer_x[15:0] : i_viewer_y[15:0];
        // Mirror for a north-south hit looking east or an east-west hit looking north.
        n_item.flip = i_hit_side ? (!i_ray_dir_x[15] && (i_ray_dir_x != 16'sd0))
                                 : i_ray_dir_y[15];
    end

    // One holding register; it frees up in the same cycle the queue takes it.
    assign push    = r_valid && i_item_ready;
    assign o_ready = !r_valid || push;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

`default_nettype wire

// ===== src/rcw_queue.sv =====
`default_nettype none

module rcw_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    input  rcw_pkg::t_item      i_push_item,
    output logic                o_push_ready,
    output logic                o_pop_valid,
    output rcw_pkg::t_item      o_pop_item,
    input  wire logic           i_pop_ready
);

    rcw_pkg::t_item                  r_mem [0:rcw_pkg::Q_DEPTH-1];
    logic [rcw_pkg::Q_AW-1:0]        r_wp;
    logic [rcw_pkg::Q_AW-1:0]        r_rp;
    logic [rcw_pkg::Q_CW-1:0]        r_cnt;
    logic                            push;
    logic                            pop;

    assign o_push_ready = (r_cnt != rcw_pkg::Q_CW'(rcw_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rp];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/rcw_back.sv =====
`default_nettype none

module rcw_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_item_valid,
    input  rcw_pkg::t_item                     i_item,
    output logic                               o_item_ready,
    input  wire logic [rcw_pkg::CFG_W-1:0]     i_tex_width,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [rcw_pkg::H_W-1:0]            o_slice_height,
    output logic [rcw_pkg::ROW_W-1:0]          o_first_row,
    output logic [rcw_pkg::ROW_W-1:0]          o_last_row,
    output logic [rcw_pkg::TEX_W-1:0]          o_texel_column,
    output logic                               o_zero_distance
);

    localparam int unsigned NS = rcw_pkg::DIV_STAGES;
    localparam logic [rcw_pkg::ROWCALC_W-1:0] ROWS_C =
        rcw_pkg::ROWCALC_W'(rcw_pkg::SCREEN_ROWS);
    localparam logic [rcw_pkg::ROWCALC_W-1:0] HALF_ROWS_C =
        rcw_pkg::ROWCALC_W'(rcw_pkg::SCREEN_ROWS / 2);

    logic [NS:0]              r_vld;
    rcw_pkg::t_stage          r_stg [0:NS];
    rcw_pkg::t_stage          n_stg [0:NS];
    logic                     r_out_valid;
    logic                     en;
    logic                     pop;
    logic [rcw_pkg::H_W-1:0]  height;
    logic [rcw_pkg::ROWCALC_W-1:0] two_half;
    logic [rcw_pkg::ROWCALC_W-1:0] first_c;
    logic [rcw_pkg::ROWCALC_W-1:0] last_c;

    // The whole pipeline advances together whenever the output slot can move.
    assign en           = !r_out_valid || i_ready;
    assign pop          = en && i_item_valid;
    assign o_item_ready = en;

    // Stage logic: load, one restoring divide step per stage, texture column steps.
    always_comb begin
        logic [rcw_pkg::DIST_W-1:0]    rem_sh;
        logic                          qbit;
        logic [rcw_pkg::FRAC_W-1:0]    dir_ext;
        logic [2*rcw_pkg::FRAC_W-1:0]  mul_full;
        logic [rcw_pkg::FRAC_W+rcw_pkg::CFG_W-1:0] scale;

        rem_sh   = '0;
        qbit     = 1'b0;
        dir_ext  = '0;
        mul_full = '0;
        scale    = '0;

        n_stg[0].rem  = rcw_pkg::DIST_W'(rcw_pkg::SCREEN_ROWS);
        n_stg[0].quo  = '0;
        n_stg[0].mag  = i_item.mag;
        n_stg[0].sat  = (i_item.mag <= rcw_pkg::MAG_W'(rcw_pkg::SCREEN_ROWS));
        n_stg[0].zero = (i_item.mag == '0);
        n_stg[0].perp_dist = i_item.perp_dist;
        n_stg[0].dir  = i_item.dir;
        n_stg[0].pos  = i_item.pos;
        n_stg[0].flip = i_item.flip;
        n_stg[0].frac = '0;
        n_stg[0].tex  = '0;

        for (int k = 1; k <= NS; k++) begin
            n_stg[k] = r_stg[k-1];

            // Quotient bit: the dividend's low 16 bits are zero, so only a shift.
            rem_sh = {r_stg[k-1].rem[rcw_pkg::DIST_W-2:0], 1'b0};
            qbit   = (rem_sh >= {1'b0, r_stg[k-1].mag});
            if (qbit) begin
                n_stg[k].rem = rem_sh - {1'b0, r_stg[k-1].mag};
            end else begin
                n_stg[k].rem = rem_sh;
            end
            n_stg[k].quo = {r_stg[k-1].quo[rcw_pkg::H_W-2:0], qbit};

            // Texture column, one step per stage in the early part of the pipe.
            if (k == rcw_pkg::STG_MUL) begin
                dir_ext  = {{(rcw_pkg::FRAC_W-rcw_pkg::DIR_W){r_stg[k-1].dir[rcw_pkg::DIR_W-1]}},
                            r_stg[k-1].dir};
                mul_full = r_stg[k-1].perp_dist[rcw_pkg::FRAC_W-1:0] * dir_ext;
                n_stg[k].frac = mul_full[rcw_pkg::FRAC_W-1:0];
            end else if (k == rcw_pkg::STG_FRAC) begin
                n_stg[k].frac = {r_stg[k-1].pos, {(rcw_pkg::FRAC_W-rcw_pkg::POS_W){1'b0}}}
                                + r_stg[k-1].frac;
            end else if (k == rcw_pkg::STG_SCALE) begin
                scale = {{rcw_pkg::CFG_W{1'b0}}, r_stg[k-1].frac}
                        * {{rcw_pkg::FRAC_W{1'b0}}, i_tex_width};
                n_stg[k].tex = scale[rcw_pkg::FRAC_W+rcw_pkg::CFG_W-1:rcw_pkg::FRAC_W];
            end else if (k == rcw_pkg::STG_MIRROR) begin
                if (i_tex_width == '0) begin
                    n_stg[k].tex = '0;
                end else if (r_stg[k-1].flip) begin
                    n_stg[k].tex = i_tex_width - r_stg[k-1].tex - 1'b1;
                end
            end
        end
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[NS-1:0], pop};
            r_out_valid <= r_vld[NS];
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= NS; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Final height with saturation, and the rows centered on the screen.
    always_comb begin
        height   = r_stg[NS].sat ? {rcw_pkg::H_W{1'b1}} : r_stg[NS].quo;
        two_half = rcw_pkg::ROWCALC_W'({height[rcw_pkg::H_W-1:1], 1'b0});
        if (two_half > ROWS_C) begin
            first_c = '0;
        end else begin
            first_c = (ROWS_C - two_half) >> 1;
        end
        last_c = rcw_pkg::ROWCALC_W'(height[rcw_pkg::H_W-1:1]) + HALF_ROWS_C;
        if (last_c >= ROWS_C) begin
            last_c = ROWS_C - 1'b1;
        end
    end

    // Output register; the pipeline takes requests behind it only while this register can move.
    always_ff @(posedge i_clk) begin
        if (en && r_vld[NS]) begin
            o_slice_height  <= height;
            o_first_row     <= first_c[rcw_pkg::ROW_W-1:0];
            o_last_row      <= last_c[rcw_pkg::ROW_W-1:0];
            o_texel_column  <= r_stg[NS].tex[rcw_pkg::TEX_W-1:0];
            o_zero_distance <= r_stg[NS].zero;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== src/rcw_checker.sv =====
`default_nettype none

module rcw_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      o_valid,
    input  wire logic                      i_ready,
    input  wire logic [rcw_pkg::H_W-1:0]   o_slice_height,
    input  wire logic [rcw_pkg::ROW_W-1:0] o_first_row,
    input  wire logic [rcw_pkg::ROW_W-1:0] o_last_row,
    input  wire logic                      o_zero_distance
);

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_slice_height) && $stable(o_last_row))
        else $error("result changed while stalled");

    // A zero distance always comes with the saturated height.
    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_distance |-> o_slice_height == {rcw_pkg::H_W{1'b1}})
        else $error("zero distance without saturated height");

    // Rows stay on the screen and the top never passes the bottom.
    a_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row <= rcw_pkg::ROW_W'(rcw_pkg::SCREEN_ROWS - 1))
                    && (o_first_row <= o_last_row))
        else $error("row range out of bounds");

    // Coming out of reset no result is shown.
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind raycast_wall_column_setup_unit rcw_checker u_rcw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_slice_height  (o_slice_height),
    .o_first_row     (o_first_row),
    .o_last_row      (o_last_row),
    .o_zero_distance (o_zero_distance)
);

`default_nettype wire

// ===== tb/raycast_column_checker.sv =====
`default_nettype none

module raycast_column_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request channel as seen at the block.
    input  wire logic                          i_valid,
    input  wire logic                          o_ready,
    input  wire logic                          i_hit_side,
    input  wire logic [31:0]                   i_side_dist_x,
    input  wire logic [31:0]                   i_delta_dist_x,
    input  wire logic [31:0]                   i_side_dist_y,
    input  wire logic [31:0]                   i_delta_dist_y,
    input  wire logic signed [15:0]            i_ray_dir_x,
    input  wire logic signed [15:0]            i_ray_dir_y,
    input  wire logic [23:0]                   i_viewer_x,
    input  wire logic [23:0]                   i_viewer_y,
    // Result channel as seen at the block.
    input  wire logic                          o_valid,
    input  wire logic                          i_ready,
    input  wire logic [rcw_pkg::H_W-1:0]       o_slice_height,
    input  wire logic [rcw_pkg::ROW_W-1:0]     o_first_row,
    input  wire logic [rcw_pkg::ROW_W-1:0]     o_last_row,
    input  wire logic [rcw_pkg::TEX_W-1:0]     o_texel_column,
    input  wire logic                          o_zero_distance,
    // Register port as seen at the block.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rcw_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [rcw_pkg::PDATA_W-1:0]   pwdata,
    input  wire logic [rcw_pkg::PDATA_W-1:0]   prdata,
    input  wire logic                          pready,
    // Status handed to the testbench top.
    output int                                 mismatch_count,
    output int                                 results_pending,
    output int                                 results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rcw_pkg::PADDR_W-1:0] TEX_WIDTH_ADDR =
        {rcw_pkg::REG_TEXTURE_WIDTH, 2'b00};
    localparam int unsigned REPORT_LINES = 30;

    typedef struct packed {
        logic [rcw_pkg::H_W-1:0]   height;
        logic [rcw_pkg::ROW_W-1:0] first_row;
        logic [rcw_pkg::ROW_W-1:0] last_row;
        logic [rcw_pkg::TEX_W-1:0] texel;
        logic                      zero;
    } t_column_result;

    t_column_result            expected_columns[$];
    logic [rcw_pkg::CFG_W-1:0] texture_width = rcw_pkg::TEX_WIDTH_RESET;
    int                        mismatches = 0;
    int                        checked = 0;
    int                        pending = 0;

    assign mismatch_count  = mismatches;
    assign results_checked = checked;
    assign results_pending = pending;

    // Print the first few failures and count all of them.
    task automatic report_failure(input string msg);
        if (mismatches < REPORT_LINES) begin
            $display("[%0t] FAIL: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Perpendicular distance, projected slice height, clamped rows and the
    // mirrored texture column for one column request.
    function automatic t_column_result project_column(
        input logic                             side,
        input logic [31:0]                      sx,
        input logic [31:0]                      dx,
        input logic [31:0]                      sy,
        input logic [31:0]                      dy,
        input logic signed [rcw_pkg::DIR_W-1:0] rdx,
        input logic signed [rcw_pkg::DIR_W-1:0] rdy,
        input logic [23:0]                      vx,
        input logic [23:0]                      vy,
        input logic [rcw_pkg::CFG_W-1:0]        width
    );
        logic signed [63:0] perp_dist;
        logic signed [63:0] dir;
        logic [63:0]        mag;
        logic [63:0]        height;
        logic [63:0]        half;
        logic [63:0]        top_row;
        logic [63:0]        bottom_row;
        logic [63:0]        pos;
        logic [63:0]        frac;
        logic [63:0]        texel;
        logic               flip;
        t_column_result     res;

        // The distance keeps its sign; only the height uses the magnitude.
        perp_dist = side ? $signed({32'd0, sy}) - $signed({32'd0, dy})
                         : $signed({32'd0, sx}) - $signed({32'd0, dx});
        mag = (perp_dist < 0) ? 64'(-perp_dist) : 64'(perp_dist);

        // A zero distance saturates the height just like a tiny one.
        if (mag == 0) begin
            height = 64'd65535;
        end else begin
            height = (64'(rcw_pkg::SCREEN_ROWS) << 16) / mag;
            if (height > 64'd65535) begin
                height = 64'd65535;
            end
        end

        // Rows are centered on the screen and clamped to it.
        half = height >> 1;
        if (64'(rcw_pkg::SCREEN_ROWS) < (half << 1)) begin
            top_row = 0;
        end else begin
            top_row = (64'(rcw_pkg::SCREEN_ROWS) - (half << 1)) >> 1;
        end
        bottom_row = half + 64'(rcw_pkg::SCREEN_ROWS / 2);
        if (bottom_row >= 64'(rcw_pkg::SCREEN_ROWS)) begin
            bottom_row = 64'(rcw_pkg::SCREEN_ROWS) - 1;
        end

        // Wall hit coordinate in Q.30; its low 30 bits are the fraction,
        // which floors negative coordinates as well.
        pos   = side ? 64'(vx) : 64'(vy);
        dir   = side ? rdx : rdy;
        frac  = ((pos << 14) + 64'(perp_dist * dir)) & 64'h3FFF_FFFF;
        texel = (frac * 64'(width)) >> 30;
        flip  = side ? (rdx > 0) : (rdy < 0);
        if (width == 0) begin
            texel = 0;
        end else if (flip) begin
            texel = 64'(width) - texel - 1;
        end

        res.height    = height[rcw_pkg::H_W-1:0];
        res.first_row = top_row[rcw_pkg::ROW_W-1:0];
        res.last_row  = bottom_row[rcw_pkg::ROW_W-1:0];
        res.texel     = texel[rcw_pkg::TEX_W-1:0];
        res.zero      = (mag == 0);
        return res;
    endfunction

    // Watch all three ports at each rising edge.
    always @(posedge i_clk) begin : watch_ports
        t_column_result want;
        if (!i_rst_n) begin
            texture_width = rcw_pkg::TEX_WIDTH_RESET;
            expected_columns.delete();
        end else begin
            // Track register writes and check read data.
            if (psel && penable && pready && paddr == TEX_WIDTH_ADDR) begin
                if (pwrite) begin
                    texture_width = pwdata[rcw_pkg::CFG_W-1:0];
                end else if (prdata !==
                             {{(rcw_pkg::PDATA_W-rcw_pkg::CFG_W){1'b0}}, texture_width}) begin
                    report_failure($sformatf("texture_width read 0x%0h, expected 0x%0h",
                        prdata, texture_width));
                end
            end

            // Every accepted request predicts exactly one result.
            if (i_valid && o_ready) begin
                expected_columns.push_back(project_column(i_hit_side,
                    i_side_dist_x, i_delta_dist_x, i_side_dist_y, i_delta_dist_y,
                    i_ray_dir_x, i_ray_dir_y, i_viewer_x, i_viewer_y, texture_width));
            end

            // Compare each accepted result with the oldest prediction.
            if (o_valid && i_ready) begin
                if (expected_columns.size() == 0) begin
                    report_failure("result with no request outstanding");
                end else begin
                    want = expected_columns.pop_front();
                    if (o_slice_height !== want.height) begin
                        report_failure($sformatf("result %0d slice_height 0x%0h, expected 0x%0h",
                            checked, o_slice_height, want.height));
                    end
                    if (o_first_row !== want.first_row) begin
                        report_failure($sformatf("result %0d first_row 0x%0h, expected 0x%0h",
                            checked, o_first_row, want.first_row));
                    end
                    if (o_last_row !== want.last_row) begin
                        report_failure($sformatf("result %0d last_row 0x%0h, expected 0x%0h",
                            checked, o_last_row, want.last_row));
                    end
                    if (o_texel_column !== want.texel) begin
                        report_failure($sformatf("result %0d texel_column 0x%0h, expected 0x%0h",
                            checked, o_texel_column, want.texel));
                    end
                    if (o_zero_distance !== want.zero) begin
                        report_failure($sformatf("result %0d zero_distance %0b, expected %0b",
                            checked, o_zero_distance, want.zero));
                    end
                    checked++;
                end
            end
        end
        pending <= expected_columns.size();
    end

endmodule

`default_nettype wire

// ===== tb/raycast_wall_column_setup_unit_tb.sv =====
`default_nettype none

module raycast_wall_column_setup_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rcw_pkg::PADDR_W-1:0] TEX_WIDTH_ADDR =
        {rcw_pkg::REG_TEXTURE_WIDTH, 2'b00};
    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned RANDOM_PER_PHASE = 166;
    localparam int unsigned WIDTH_PHASES     = 11;
    localparam int unsigned DRAIN_TAIL       = 40;
    localparam logic [31:0] Q16_ONE          = 32'h0001_0000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic                          i_hit_side;
    logic [31:0]                   i_side_dist_x;
    logic [31:0]                   i_delta_dist_x;
    logic [31:0]                   i_side_dist_y;
    logic [31:0]                   i_delta_dist_y;
    logic signed [15:0]            i_ray_dir_x;
    logic signed [15:0]            i_ray_dir_y;
    logic [23:0]                   i_viewer_x;
    logic [23:0]                   i_viewer_y;
    logic                          o_valid;
    logic                          i_ready;
    logic [rcw_pkg::H_W-1:0]       o_slice_height;
    logic [rcw_pkg::ROW_W-1:0]     o_first_row;
    logic [rcw_pkg::ROW_W-1:0]     o_last_row;
    logic [rcw_pkg::TEX_W-1:0]     o_texel_column;
    logic                          o_zero_distance;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [rcw_pkg::PADDR_W-1:0]   paddr;
    logic [rcw_pkg::PDATA_W-1:0]   pwdata;
    logic [rcw_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    int mismatch_count;
    int results_pending;
    int results_checked;
    int columns_sent = 0;
    int widths_used = 0;
    bit flood = 1'b0;

    always #1 i_clk = ~i_clk;

    raycast_wall_column_setup_unit dut (.*);

    raycast_column_checker checker_inst (.*);

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // One register port transfer: setup cycle, access cycle, then the bus goes idle.
    task automatic apb_transfer(input logic write,
                                input logic [rcw_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= TEX_WIDTH_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write the width with junk in the unused upper bits, then read it back.
    task automatic set_texture_width(input logic [rcw_pkg::CFG_W-1:0] width);
        logic [rcw_pkg::PDATA_W-1:0] data;
        data = $urandom;
        data[rcw_pkg::CFG_W-1:0] = width;
        apb_transfer(1'b1, data);
        apb_transfer(1'b0, '0);
        widths_used++;
    endtask

    // Present one column request and hold it until it is taken.
    task automatic send_column(
        input logic        side,
        input logic [31:0] sx,
        input logic [31:0] dx,
        input logic [31:0] sy,
        input logic [31:0] dy,
        input logic [15:0] rdx,
        input logic [15:0] rdy,
        input logic [23:0] vx,
        input logic [23:0] vy
    );
        int unsigned gap;
        gap = flood ? 0 : random_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_hit_side     <= side;
        i_side_dist_x  <= sx;
        i_delta_dist_x <= dx;
        i_side_dist_y  <= sy;
        i_delta_dist_y <= dy;
        i_ray_dir_x    <= rdx;
        i_ray_dir_y    <= rdy;
        i_viewer_x     <= vx;
        i_viewer_y     <= vy;
        do @(posedge i_clk); while (!o_ready);
        columns_sent++;
    endtask

    // Mostly plausible hits with a positive distance, plus zero and negative
    // distances and a share of fully random side and delta values.
    task automatic send_random_column();
        logic        side;
        logic [31:0] hit_delta;
        logic [31:0] hit_sum;
        logic [31:0] cross_delta;
        logic [31:0] cross_sum;
        int unsigned shape;
        side        = 1'($urandom);
        shape       = $urandom_range(0, 99);
        cross_delta = $urandom;
        cross_sum   = $urandom;
        hit_delta   = ($urandom_range(0, 3) == 0) ? $urandom
                                                  : $urandom_range(32'h0000_4000, 32'h0080_0000);
        if (shape < 8) begin
            hit_sum = hit_delta;
        end else if (shape < 18) begin
            hit_sum = hit_delta - $urandom_range(1, 32'h0040_0000);
        end else if (shape < 32) begin
            hit_sum = hit_delta + $urandom_range(1, 32'h0000_FFFF);
        end else if (shape < 85) begin
            hit_sum = hit_delta + $urandom_range(32'h0000_8000, 32'h0040_0000);
        end else begin
            hit_sum   = $urandom;
            hit_delta = $urandom;
        end
        if (side) begin
            send_column(side, cross_sum, cross_delta, hit_sum, hit_delta,
                16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
        end else begin
            send_column(side, hit_sum, hit_delta, cross_sum, cross_delta,
                16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
        end
    endtask

    // Stop sending and wait until every request has its result.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    // Result side back-pressure: short stalls, long bursts with none at all.
    initial begin : result_pacing
        int unsigned burst;
        int unsigned stall;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 8);
            i_ready <= 1'b1;
            repeat (burst) @(posedge i_clk);
            stall = random_gap();
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // End the run if nothing moves on either channel for too long.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog expired with %0d results outstanding", results_pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus: directed corner cases, then random phases at several widths.
    initial begin : stimulus
        logic [rcw_pkg::CFG_W-1:0] phase_widths[8];
        logic [rcw_pkg::CFG_W-1:0] width;
        phase_widths = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'd1025, 11'd640, 11'd3, 11'd64};

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_hit_side     <= 1'b0;
        i_side_dist_x  <= '0;
        i_delta_dist_x <= '0;
        i_side_dist_y  <= '0;
        i_delta_dist_y <= '0;
        i_ray_dir_x    <= '0;
        i_ray_dir_y    <= '0;
        i_viewer_x     <= '0;
        i_viewer_y     <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset width must read back before anything is written.
        apb_transfer(1'b0, '0);

        // Zero distance on both sides, each with mirroring.
        send_column(1'b0, 32'h0003_0000, 32'h0003_0000, $urandom, $urandom,
            16'h4000, 16'hC000, 24'h12_3456, 24'h65_4321);
        send_column(1'b1, $urandom, $urandom, 32'h0002_8000, 32'h0002_8000,
            16'h4000, 16'h4000, 24'hAB_CDEF, 24'h00_0000);
        // Negative distances where the side distance is below the delta.
        send_column(1'b0, 32'h0000_8000, 32'h0001_8000, $urandom, $urandom,
            16'h1234, 16'h2345, 24'h01_8000, 24'h02_4000);
        send_column(1'b1, $urandom, $urandom, 32'h0000_0000, 2 * Q16_ONE,
            16'hE000, 16'h2000, 24'h03_C000, 24'h04_2000);
        // Largest and most negative distances.
        send_column(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom,
            16'h7FFF, 16'h8000, 24'h00_0001, 24'hFF_FFFF);
        send_column(1'b1, $urandom, $urandom, 32'h0000_0000, 32'hFFFF_FFFF,
            16'h8000, 16'h7FFF, 24'hFF_FFFF, 24'h00_0001);
        send_column(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom,
            16'h0001, 16'h0001, 24'h55_5555, 24'hAA_AAAA);
        // Smallest nonzero distance saturates without the zero flag.
        send_column(1'b0, 32'h0000_0001, 32'h0000_0000, $urandom, $urandom,
            16'h8000, 16'h0000, 24'h10_0000, 24'h20_0000);
        // Distances around one unit: full screen, half screen, odd height.
        send_column(1'b0, 2 * Q16_ONE, Q16_ONE, $urandom, $urandom,
            16'h8000, 16'h0000, 24'h01_2000, 24'h05_9000);
        send_column(1'b1, $urandom, $urandom, 3 * Q16_ONE, Q16_ONE,
            16'h0000, 16'h4000, 24'h07_7000, 24'h00_3000);
        send_column(1'b0, 32'h0001_0040, 32'h0000_0000, $urandom, $urandom,
            16'h2000, 16'h3000, 24'h00_C000, 24'h09_1000);
        send_column(1'b1, $urandom, $urandom, 5 * Q16_ONE, Q16_ONE,
            16'hC000, 16'h4000, 24'h0A_0000, 24'h0B_8000);
        send_column(1'b0, 32'h0000_8000, 32'h0000_0000, $urandom, $urandom,
            16'h4000, 16'h4000, 24'h0C_4000, 24'h0D_2000);
        // Direction and position extremes, mirroring on each side.
        send_column(1'b0, 32'h0003_4000, 32'h0000_0000, $urandom, $urandom,
            16'h0000, 16'h7FFF, 24'h00_0000, 24'hFF_FFFF);
        send_column(1'b1, $urandom, $urandom, 32'h0002_6000, 32'h0000_0000,
            16'h8000, 16'h0000, 24'hFF_FFFF, 24'h00_0000);
        send_column(1'b1, $urandom, $urandom, 32'h0001_A000, 32'h0000_0000,
            16'h0001, 16'hFFFF, 24'h12_0000, 24'h34_0000);
        send_column(1'b0, 32'h0004_3000, 32'h0000_0000, $urandom, $urandom,
            16'h0001, 16'hFFFF, 24'h56_0000, 24'h78_0000);
        // All-ones and all-zero requests.
        send_column(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        send_column(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
            16'h0000, 16'h0000, 24'h00_0000, 24'h00_0000);
        // Far walls: tiny and vanishing heights.
        send_column(1'b1, $urandom, $urandom, 32'h8000_0000, 32'h0000_0000,
            16'h3FFF, 16'hC001, 24'h80_0000, 24'h7F_FFFF);
        send_column(1'b0, 32'h0100_0000, 32'h0000_0000, $urandom, $urandom,
            16'h5A5A, 16'hA5A5, 24'h5A_5A5A, 24'hA5_A5A5);
        send_column(1'b1, $urandom, $urandom, 32'h0400_0000, 32'h0000_0000,
            16'hA5A5, 16'h5A5A, 24'hA5_A5A5, 24'h5A_5A5A);
        drain_results();

        // Random phases, each at its own texture width.
        for (int phase = 0; phase < WIDTH_PHASES; phase++) begin
            width = (phase < 8) ? phase_widths[phase] : 11'($urandom_range(0, 2047));
            set_texture_width(width);
            flood = (phase % 3 == 1);
            repeat (RANDOM_PER_PHASE) send_random_column();
            drain_results();
        end
        flood = 1'b0;

        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("Sent %0d column requests over %0d texture width settings after reset.",
            columns_sent, widths_used);
        $display("Compared %0d results field by field; %0d mismatches found.",
            results_checked, mismatch_count);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
